[rtl/cpu6502_pkg.sv]
// ----------------------------------------------------------------------------
// cpu6502_pkg - shared types and constants for the 6502 execute unit
// Operation codes, architectural register state and its reset value.
// ----------------------------------------------------------------------------
package cpu6502_pkg;

  // Operation codes, alphabetical by mnemonic; stack and interrupt ops absent.
  // Codes 47 to 63 are unused and behave as NOP.
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
    OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
    OP_ROL = 6'd32, OP_ROR = 6'd33, OP_SBC = 6'd34, OP_SEC = 6'd35,
    OP_SED = 6'd36, OP_SEI = 6'd37, OP_STA = 6'd38, OP_STX = 6'd39,
    OP_STY = 6'd40, OP_TAX = 6'd41, OP_TAY = 6'd42, OP_TSX = 6'd43,
    OP_TXA = 6'd44, OP_TXS = 6'd45, OP_TYA = 6'd46
  } op_t;

  // Bit positions within a data byte
  localparam int SIGN_BIT = 7;
  localparam int BIT6     = 6;

  // Stack pointer low byte after reset
  localparam logic [7:0] SP_RESET = 8'hFD;

  // Processor flags
  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  // Architectural register state
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flags_t     fl;
  } arch_state_t;

  localparam arch_state_t STATE_RESET = '{
    acc: 8'h00,
    x:   8'h00,
    y:   8'h00,
    sp:  SP_RESET,
    fl:  '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0}
  };

  // Pack flags as N V 1 0 D I Z C
  function automatic logic [7:0] pack_status(flags_t f);
    return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
  endfunction

endpackage

[rtl/cpu6502_alu.sv]
// ----------------------------------------------------------------------------
// cpu6502_alu - single-step operation logic
// Computes the next register state, write-back byte and branch condition
// for one operation from the current state and the memory operand.
// ----------------------------------------------------------------------------
module cpu6502_alu
  import cpu6502_pkg::*;
(
  input  logic [5:0]  op,
  input  logic [7:0]  operand,
  input  arch_state_t st,
  output arch_state_t st_next,
  output logic [7:0]  result_value,
  output logic        branch_taken
);

  logic [7:0] addend;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;

  // Shared adder for ADC and SBC (SBC adds the inverted operand)
  assign addend = (op == OP_SBC) ? ~operand : operand;
  assign sum    = {1'b0, st.acc} + {1'b0, addend} + {8'h00, st.fl.c};

  // Shared subtractor for the compares
  always_comb begin
    case (op)
      OP_CPX:  cmp_reg = st.x;
      OP_CPY:  cmp_reg = st.y;
      default: cmp_reg = st.acc;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, operand};

  always_comb begin
    logic [7:0] zn_val;
    logic       zn_en;
    zn_val       = 8'h00;
    zn_en        = 1'b0;
    st_next      = st;
    result_value = operand;
    branch_taken = 1'b0;

    case (op)
      OP_ADC, OP_SBC: begin
        st_next.acc  = sum[7:0];
        st_next.fl.c = sum[8];
        st_next.fl.v = ~(st.acc[SIGN_BIT] ^ addend[SIGN_BIT]) &
                       (st.acc[SIGN_BIT] ^ sum[SIGN_BIT]);
        zn_val = sum[7:0];
        zn_en  = 1'b1;
      end
      OP_AND: begin
        st_next.acc = st.acc & operand; zn_val = st.acc & operand; zn_en = 1'b1;
      end
      OP_EOR: begin
        st_next.acc = st.acc ^ operand; zn_val = st.acc ^ operand; zn_en = 1'b1;
      end
      OP_ORA: begin
        st_next.acc = st.acc | operand; zn_val = st.acc | operand; zn_en = 1'b1;
      end
      OP_ASL: begin
        st_next.fl.c = operand[SIGN_BIT];
        result_value = {operand[6:0], 1'b0};
        zn_val = {operand[6:0], 1'b0}; zn_en = 1'b1;
      end
      OP_LSR: begin
        st_next.fl.c = operand[0];
        result_value = {1'b0, operand[7:1]};
        zn_val = {1'b0, operand[7:1]}; zn_en = 1'b1;
      end
      OP_ROL: begin
        st_next.fl.c = operand[SIGN_BIT];
        result_value = {operand[6:0], st.fl.c};
        zn_val = {operand[6:0], st.fl.c}; zn_en = 1'b1;
      end
      OP_ROR: begin
        st_next.fl.c = operand[0];
        result_value = {st.fl.c, operand[7:1]};
        zn_val = {st.fl.c, operand[7:1]}; zn_en = 1'b1;
      end
      // Branch conditions
      OP_BCC: branch_taken = ~st.fl.c;
      OP_BCS: branch_taken = st.fl.c;
      OP_BEQ: branch_taken = st.fl.z;
      OP_BNE: branch_taken = ~st.fl.z;
      OP_BMI: branch_taken = st.fl.n;
      OP_BPL: branch_taken = ~st.fl.n;
      OP_BVC: branch_taken = ~st.fl.v;
      OP_BVS: branch_taken = st.fl.v;
      // BIT: N and V from the operand, Z from A and operand
      OP_BIT: begin
        st_next.fl.v = operand[BIT6];
        st_next.fl.n = operand[SIGN_BIT];
        st_next.fl.z = ((st.acc & operand) == 8'h00);
        result_value = st.acc & operand;
      end
      // Flag set and clear
      OP_CLC: st_next.fl.c = 1'b0;
      OP_CLD: st_next.fl.d = 1'b0;
      OP_CLI: st_next.fl.i = 1'b0;
      OP_CLV: st_next.fl.v = 1'b0;
      OP_SEC: st_next.fl.c = 1'b1;
      OP_SED: st_next.fl.d = 1'b1;
      OP_SEI: st_next.fl.i = 1'b1;
      // Compares: carry is "register >= operand"
      OP_CMP, OP_CPX, OP_CPY: begin
        st_next.fl.c = ~diff[8];
        result_value = diff[7:0];
        zn_val = diff[7:0]; zn_en = 1'b1;
      end
      // Memory increment and decrement
      OP_DEC: begin
        result_value = operand - 8'd1; zn_val = operand - 8'd1; zn_en = 1'b1;
      end
      OP_INC: begin
        result_value = operand + 8'd1; zn_val = operand + 8'd1; zn_en = 1'b1;
      end
      // Register increment and decrement
      OP_DEX: begin
        st_next.x = st.x - 8'd1; zn_val = st.x - 8'd1; zn_en = 1'b1;
      end
      OP_DEY: begin
        st_next.y = st.y - 8'd1; zn_val = st.y - 8'd1; zn_en = 1'b1;
      end
      OP_INX: begin
        st_next.x = st.x + 8'd1; zn_val = st.x + 8'd1; zn_en = 1'b1;
      end
      OP_INY: begin
        st_next.y = st.y + 8'd1; zn_val = st.y + 8'd1; zn_en = 1'b1;
      end
      // Loads
      OP_LDA: begin st_next.acc = operand; zn_val = operand; zn_en = 1'b1; end
      OP_LDX: begin st_next.x   = operand; zn_val = operand; zn_en = 1'b1; end
      OP_LDY: begin st_next.y   = operand; zn_val = operand; zn_en = 1'b1; end
      // Stores
      OP_STA: result_value = st.acc;
      OP_STX: result_value = st.x;
      OP_STY: result_value = st.y;
      // Transfers; TXS leaves the flags alone
      OP_TAX: begin st_next.x   = st.acc; zn_val = st.acc; zn_en = 1'b1; end
      OP_TAY: begin st_next.y   = st.acc; zn_val = st.acc; zn_en = 1'b1; end
      OP_TSX: begin st_next.x   = st.sp;  zn_val = st.sp;  zn_en = 1'b1; end
      OP_TXA: begin st_next.acc = st.x;   zn_val = st.x;   zn_en = 1'b1; end
      OP_TYA: begin st_next.acc = st.y;   zn_val = st.y;   zn_en = 1'b1; end
      OP_TXS: st_next.sp = st.x;
      // NOP and unused codes
      default: ;
    endcase

    // Common Z and N update
    if (zn_en) begin
      st_next.fl.z = (zn_val == 8'h00);
      st_next.fl.n = zn_val[SIGN_BIT];
    end
  end

endmodule

[rtl/cpu6502_alu_execute.sv]
// ----------------------------------------------------------------------------
// cpu6502_alu_execute - 6502 execute unit for single-step operations
// Input register, operation logic with register file, result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op and operand. A transaction
//   is taken at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries the write-back byte, the
//   registers A X Y SP after the operation, packed status N V 1 0 D I Z C
//   and branch_taken, one result transaction per input transaction.
//   The input register captures a transaction at the edge that takes it; the
//   result register takes its result when it moves on. Throughput:
//   one operation per cycle while the receiver does not stall; the register
//   file updates when an operation moves from the input to the result
//   register, so each operation sees the state left by the one before it.
//   When the receiver stalls, the result register holds, the input register
//   holds one more transaction, and in_stall rises only once both are full.
//   Reset (rst, synchronous): both channels empty, A = X = Y = 0, SP = 0xFD,
//   all flags clear except I.
// ----------------------------------------------------------------------------
module cpu6502_alu_execute
  import cpu6502_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] op,
  input  logic [7:0] operand,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result_value,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] sp_out,
  output logic [7:0] status_out,
  output logic       branch_taken
);

  logic        in_q_valid;
  logic [5:0]  in_q_op;
  logic [7:0]  in_q_operand;
  arch_state_t st;
  arch_state_t st_next;
  logic [7:0]  alu_result;
  logic        alu_branch;
  logic        out_adv;
  logic        exec_fire;

  // Handshake control
  assign out_adv   = ~out_valid | ~out_stall;
  assign in_stall  = in_q_valid & ~out_adv;
  assign exec_fire = in_q_valid & out_adv;

  // Operation logic
  cpu6502_alu u_alu (
    .op           (in_q_op),
    .operand      (in_q_operand),
    .st           (st),
    .st_next      (st_next),
    .result_value (alu_result),
    .branch_taken (alu_branch)
  );

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      st         <= STATE_RESET;
    end else begin
      if (~in_stall) in_q_valid <= in_valid;
      if (out_adv) out_valid <= in_q_valid;
      if (exec_fire) st <= st_next;
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (~in_stall && in_valid) begin
      in_q_op      <= op;
      in_q_operand <= operand;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      result_value <= alu_result;
      acc_out      <= st_next.acc;
      x_out        <= st_next.x;
      y_out        <= st_next.y;
      sp_out       <= st_next.sp;
      status_out   <= pack_status(st_next.fl);
      branch_taken <= alu_branch;
    end
  end

endmodule
